[src/rblm_pkg.sv]
// Package for the ring bloom LED mapper: sizes, arithmetic constants and shared types.
// Used by rblm_div, the top level and the checker; depends on nothing else.
package rblm_pkg;

  // Strip storage
  localparam int STRIP_MAX = 256;
  localparam int STRIP_AW  = $clog2(STRIP_MAX);
  localparam int CNT_W     = $clog2(STRIP_MAX + 1);

  // Ring geometry
  localparam int RING_LEDS = 24;
  localparam int LED_AW    = $clog2(RING_LEDS);
  localparam int HALF_RING = RING_LEDS / 2;
  localparam int DIST_W    = $clog2(HALF_RING + 1);
  localparam int ROUND_UP  = HALF_RING - 1;

  // Origin count register
  localparam int ORG_W   = 3;
  localparam int ORG_MIN = 1;
  localparam int ORG_MAX = 6;

  // Colour channels
  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int PIX_W  = CH_W * NUM_CH;
  localparam int SUM_W  = CH_W + STRIP_AW;

  // Index scaling: x / 12 is done as (x >> 2) / 3, with / 3 as a multiply by 683 >> 11.
  localparam int PROD_W    = 12;
  localparam int XQ_W      = PROD_W - 2;
  localparam int RECIP3    = 683;
  localparam int RECIP3_SH = 11;
  localparam int MUL_W     = 2 * XQ_W;

  // Stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_arr_t;
  typedef logic [NUM_CH-1:0][CH_W-1:0]  quo_arr_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

[src/rblm_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package dependency.
module rblm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/rblm_div.sv]
// Three-channel restoring divider, one quotient bit per cycle, shared divisor.
// Depends on rblm_pkg for widths and the request type.
module rblm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rblm_pkg::div_req_t req,
  input  rblm_pkg::sum_arr_t dividend,
  output logic               done,
  output rblm_pkg::quo_arr_t quotient
);

  localparam int ITER_W = $clog2(rblm_pkg::SUM_W + 1);

  logic                                               busy_r, busy_nxt;
  logic                                               done_r, done_nxt;
  logic [ITER_W-1:0]                                  iter_r, iter_nxt;
  logic [rblm_pkg::CNT_W-1:0]                         dvs_r, dvs_nxt;
  logic [rblm_pkg::NUM_CH-1:0][rblm_pkg::CNT_W-1:0]   rem_r, rem_nxt;
  rblm_pkg::sum_arr_t                                 quo_r, quo_nxt;
  logic [rblm_pkg::NUM_CH-1:0][rblm_pkg::CNT_W:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    for (int c = 0; c < rblm_pkg::NUM_CH; c++) begin
      trial[c] = {rem_r[c], quo_r[c][rblm_pkg::SUM_W-1]};
    end
    if (req.start) begin
      busy_nxt = 1'b1;
      iter_nxt = ITER_W'(rblm_pkg::SUM_W);
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      for (int c = 0; c < rblm_pkg::NUM_CH; c++) begin
        if (trial[c] >= {1'b0, dvs_r}) begin
          rem_nxt[c] = rblm_pkg::CNT_W'(trial[c] - {1'b0, dvs_r});
          quo_nxt[c] = {quo_r[c][rblm_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt[c] = trial[c][rblm_pkg::CNT_W-1:0];
          quo_nxt[c] = {quo_r[c][rblm_pkg::SUM_W-2:0], 1'b0};
        end
      end
      iter_nxt = iter_r - 1'b1;
      if (iter_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  // An average never exceeds one channel value, so the low bits carry the quotient.
  always_comb begin
    for (int c = 0; c < rblm_pkg::NUM_CH; c++) begin
      quotient[c] = quo_r[c][rblm_pkg::CH_W-1:0];
    end
  end

  assign done = done_r;

endmodule

[src/ring_bloom_led_mapper_unit.sv]
// Top level of the ring bloom LED mapper: strip capture, span averaging, frame compare, emission.
// Depends on rblm_pkg, rblm_ram (strip, current and previous frame stores) and rblm_div.

// The block takes strip pixels one transaction per clock cycle and writes each into the strip
// memory until 256 are held; further pixels are dropped, but a pixel with in_tlast set always
// ends the frame. At the end of a frame the input stalls while each of the 24 ring LEDs is
// worked out in turn: index arithmetic, a read of each strip pixel in the LED's span through
// the strip memory's single read port, a drain step, a start of the bit-serial divider, a
// wait on it, and a write of the result. An n-pixel strip gives a span of roughly
// (n-1)*origin_count/12 + 2 pixels. A final step checks whether the frame differs from the
// last one sent. If it does, or none has been sent since reset, the 24 colours are emitted in
// ring order, green, red and blue, each transaction held until out_tready takes it; an
// unchanged frame emits nothing. The origin count register may be written whenever the block
// is idle; writes of zero are taken as one and writes above six as six.
module ring_bloom_led_mapper_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration: origin_count
  input  logic                                 cfg_wr_en,
  input  logic [rblm_pkg::ORG_W-1:0]           cfg_wr_data,
  // Strip pixels
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rblm_pkg::IN_TDATA_W-1:0]      in_tdata,  // pix_red, pix_green, pix_blue
  input  logic                                 in_tlast,  // last_pixel
  // Ring colours
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rblm_pkg::OUT_TDATA_W-1:0]     out_tdata, // ring_index, out_green, out_red,
                                                          // out_blue, zero padding
  output logic                                 out_tlast  // last_led
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCALE,
    ST_SUM,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_WRITE,
    ST_DECIDE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [rblm_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [rblm_pkg::STRIP_AW-1:0]   nm1_r, nm1_nxt;
  logic [rblm_pkg::ORG_W-1:0]      org_r, org_nxt;
  logic [rblm_pkg::LED_AW-1:0]     led_r, led_nxt;
  logic [rblm_pkg::LED_AW-1:0]     res_r, res_nxt;
  logic [rblm_pkg::XQ_W-1:0]       xlo_r, xlo_nxt;
  logic [rblm_pkg::XQ_W-1:0]       xhi_r, xhi_nxt;
  logic [rblm_pkg::STRIP_AW-1:0]   hi_r, hi_nxt;
  logic [rblm_pkg::STRIP_AW-1:0]   k_r, k_nxt;
  logic [rblm_pkg::CNT_W-1:0]      span_r, span_nxt;
  logic                            rdv_r, rdv_nxt;
  rblm_pkg::sum_arr_t              sum_r, sum_nxt;
  logic [rblm_pkg::PIX_W-1:0]      prevw_r, prevw_nxt;
  logic                            diff_r, diff_nxt;
  logic                            pvalid_r, pvalid_nxt;
  logic [rblm_pkg::OUT_TDATA_W-1:0] odata_r, odata_nxt;
  logic                            olast_r, olast_nxt;
  logic                            ovalid_r, ovalid_nxt;

  // Memory ports
  logic                            strip_we, strip_re;
  logic [rblm_pkg::PIX_W-1:0]      strip_rdata;
  logic                            cur_we, cur_re;
  logic [rblm_pkg::PIX_W-1:0]      cur_wdata, cur_rdata;
  logic                            prev_we, prev_re;
  logic [rblm_pkg::PIX_W-1:0]      prev_rdata;

  // Divider
  rblm_pkg::div_req_t              div_req;
  logic                            div_done;
  rblm_pkg::quo_arr_t              div_quo;

  // Index arithmetic
  logic [rblm_pkg::LED_AW-1:0]     dist_full;
  logic [rblm_pkg::DIST_W-1:0]     org_dist;
  logic [rblm_pkg::LED_AW-1:0]     top_full;
  logic [rblm_pkg::DIST_W-1:0]     top;
  logic [rblm_pkg::PROD_W-1:0]     a_lo, a_hi;
  logic [rblm_pkg::MUL_W-1:0]      p_lo, p_hi;
  logic [rblm_pkg::STRIP_AW-1:0]   lo_q, hi_q, lo_c, hi_c, hi_f;
  logic [rblm_pkg::LED_AW-1:0]     res_sum;
  logic                            in_acc;

  assign in_acc = in_tvalid && in_tready;

  // Distance from the current LED to its nearest origin, on the scaled ring. res_r holds
  // led*origin_count modulo 24, advanced one LED at a time.
  always_comb begin
    dist_full = (res_r <= rblm_pkg::LED_AW'(rblm_pkg::HALF_RING))
              ? res_r : (rblm_pkg::LED_AW'(rblm_pkg::RING_LEDS) - res_r);
    org_dist  = dist_full[rblm_pkg::DIST_W-1:0];
    top_full  = rblm_pkg::LED_AW'(org_dist) + rblm_pkg::LED_AW'(org_r);
    top       = (top_full > rblm_pkg::LED_AW'(rblm_pkg::HALF_RING))
              ? rblm_pkg::DIST_W'(rblm_pkg::HALF_RING) : top_full[rblm_pkg::DIST_W-1:0];
    a_lo      = rblm_pkg::PROD_W'(org_dist) * rblm_pkg::PROD_W'(nm1_r);
    a_hi      = rblm_pkg::PROD_W'(top) * rblm_pkg::PROD_W'(nm1_r)
              + rblm_pkg::PROD_W'(rblm_pkg::ROUND_UP);
    // Second stage: divide the quartered products by three.
    p_lo      = rblm_pkg::MUL_W'(xlo_r) * rblm_pkg::MUL_W'(rblm_pkg::RECIP3);
    p_hi      = rblm_pkg::MUL_W'(xhi_r) * rblm_pkg::MUL_W'(rblm_pkg::RECIP3);
    lo_q      = p_lo[rblm_pkg::RECIP3_SH +: rblm_pkg::STRIP_AW];
    hi_q      = p_hi[rblm_pkg::RECIP3_SH +: rblm_pkg::STRIP_AW];
    lo_c      = (lo_q > nm1_r) ? nm1_r : lo_q;
    hi_c      = (hi_q > nm1_r) ? nm1_r : hi_q;
    hi_f      = (hi_c < lo_c) ? lo_c : hi_c;
    res_sum   = res_r + rblm_pkg::LED_AW'(org_r);
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    nm1_nxt    = nm1_r;
    org_nxt    = org_r;
    led_nxt    = led_r;
    res_nxt    = res_r;
    xlo_nxt    = xlo_r;
    xhi_nxt    = xhi_r;
    hi_nxt     = hi_r;
    k_nxt      = k_r;
    span_nxt   = span_r;
    rdv_nxt    = 1'b0;
    sum_nxt    = sum_r;
    prevw_nxt  = prevw_r;
    diff_nxt   = diff_r;
    pvalid_nxt = pvalid_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    ovalid_nxt = ovalid_r;

    strip_we  = 1'b0;
    strip_re  = 1'b0;
    cur_we    = 1'b0;
    cur_re    = 1'b0;
    cur_wdata = {div_quo[2], div_quo[1], div_quo[0]};
    prev_we   = 1'b0;
    prev_re   = 1'b0;
    div_req   = '{start: 1'b0, divisor: span_r};

    if (cfg_wr_en) begin
      if (cfg_wr_data < rblm_pkg::ORG_W'(rblm_pkg::ORG_MIN)) begin
        org_nxt = rblm_pkg::ORG_W'(rblm_pkg::ORG_MIN);
      end else if (cfg_wr_data > rblm_pkg::ORG_W'(rblm_pkg::ORG_MAX)) begin
        org_nxt = rblm_pkg::ORG_W'(rblm_pkg::ORG_MAX);
      end else begin
        org_nxt = cfg_wr_data;
      end
    end

    // Accumulate the strip word read in the previous cycle.
    if (rdv_r) begin
      for (int c = 0; c < rblm_pkg::NUM_CH; c++) begin
        sum_nxt[c] = sum_r[c]
                   + rblm_pkg::SUM_W'(strip_rdata[c*rblm_pkg::CH_W +: rblm_pkg::CH_W]);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_r < rblm_pkg::CNT_W'(rblm_pkg::STRIP_MAX)) begin
            strip_we = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
          if (in_tlast) begin
            // The frame holds at least the pixel just taken, so n-1 never underflows.
            nm1_nxt   = rblm_pkg::STRIP_AW'(cnt_nxt - 1'b1);
            cnt_nxt   = '0;
            led_nxt   = '0;
            res_nxt   = '0;
            diff_nxt  = 1'b0;
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        xlo_nxt   = a_lo[rblm_pkg::PROD_W-1:2];
        xhi_nxt   = a_hi[rblm_pkg::PROD_W-1:2];
        prev_re   = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        hi_nxt    = hi_f;
        k_nxt     = lo_c;
        span_nxt  = rblm_pkg::CNT_W'(hi_f) - rblm_pkg::CNT_W'(lo_c) + 1'b1;
        sum_nxt   = '0;
        prevw_nxt = prev_rdata;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        strip_re = 1'b1;
        rdv_nxt  = 1'b1;
        k_nxt    = k_r + 1'b1;
        if (k_r == hi_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cur_we = 1'b1;
        if (cur_wdata != prevw_r) begin
          diff_nxt = 1'b1;
        end
        res_nxt = (res_sum >= rblm_pkg::LED_AW'(rblm_pkg::RING_LEDS))
                ? res_sum - rblm_pkg::LED_AW'(rblm_pkg::RING_LEDS) : res_sum;
        if (led_r == rblm_pkg::LED_AW'(rblm_pkg::RING_LEDS - 1)) begin
          state_nxt = ST_DECIDE;
        end else begin
          led_nxt   = led_r + 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_DECIDE: begin
        led_nxt = '0;
        if (!pvalid_r || diff_r) begin
          pvalid_nxt = 1'b1;
          state_nxt  = ST_EMIT_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        cur_re    = 1'b1;
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        prev_we    = 1'b1;
        odata_nxt  = {{(rblm_pkg::OUT_TDATA_W - rblm_pkg::LED_AW - rblm_pkg::PIX_W){1'b0}},
                      cur_rdata[2*rblm_pkg::CH_W +: rblm_pkg::CH_W],
                      cur_rdata[0 +: rblm_pkg::CH_W],
                      cur_rdata[rblm_pkg::CH_W +: rblm_pkg::CH_W],
                      led_r};
        olast_nxt  = (led_r == rblm_pkg::LED_AW'(rblm_pkg::RING_LEDS - 1));
        ovalid_nxt = 1'b1;
        state_nxt  = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          if (olast_r) begin
            state_nxt = ST_IDLE;
          end else begin
            led_nxt   = led_r + 1'b1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      org_r    <= rblm_pkg::ORG_W'(rblm_pkg::ORG_MIN);
      led_r    <= '0;
      rdv_r    <= 1'b0;
      diff_r   <= 1'b0;
      pvalid_r <= 1'b0;
      olast_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      org_r    <= org_nxt;
      led_r    <= led_nxt;
      rdv_r    <= rdv_nxt;
      diff_r   <= diff_nxt;
      pvalid_r <= pvalid_nxt;
      olast_r  <= olast_nxt;
      ovalid_r <= ovalid_nxt;
    end
    nm1_r   <= nm1_nxt;
    res_r   <= res_nxt;
    xlo_r   <= xlo_nxt;
    xhi_r   <= xhi_nxt;
    hi_r    <= hi_nxt;
    k_r     <= k_nxt;
    span_r  <= span_nxt;
    sum_r   <= sum_nxt;
    prevw_r <= prevw_nxt;
    odata_r <= odata_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  // Strip pixels, stored with red in the low byte as they arrive.
  rblm_ram #(.WIDTH(rblm_pkg::PIX_W), .DEPTH(rblm_pkg::STRIP_MAX)) u_strip_ram (
    .clk   (clk),
    .we    (strip_we),
    .waddr (cnt_r[rblm_pkg::STRIP_AW-1:0]),
    .wdata (in_tdata[rblm_pkg::PIX_W-1:0]),
    .re    (strip_re),
    .raddr (k_r),
    .rdata (strip_rdata)
  );

  // Colours of the frame being built.
  rblm_ram #(.WIDTH(rblm_pkg::PIX_W), .DEPTH(rblm_pkg::RING_LEDS)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (led_r),
    .wdata (cur_wdata),
    .re    (cur_re),
    .raddr (led_r),
    .rdata (cur_rdata)
  );

  // Colours of the last frame sent, refreshed as each colour is emitted.
  rblm_ram #(.WIDTH(rblm_pkg::PIX_W), .DEPTH(rblm_pkg::RING_LEDS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (led_r),
    .wdata (cur_rdata),
    .re    (prev_re),
    .raddr (led_r),
    .rdata (prev_rdata)
  );

  rblm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (sum_r),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

[src/rblm_chk.sv]
// Port-level checker for the ring bloom LED mapper, with its bind to the top level.
// Depends on ring_bloom_led_mapper_unit's port list and rblm_pkg.
module rblm_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_wr_en,
  input logic [rblm_pkg::ORG_W-1:0]       cfg_wr_data,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [rblm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rblm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result payload changed while stalled");

  // Pixels are never taken while a frame is being emitted.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready during emission");

  // Only the final ring LED carries the frame marker.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[rblm_pkg::LED_AW-1:0] ==
                                rblm_pkg::LED_AW'(rblm_pkg::RING_LEDS - 1))
    else $error("frame marker on wrong ring LED");

  // A taken result that is not the last keeps the input stalled for the next one.
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready)
    else $error("emission ended before the final ring LED");

  // The block is ready for pixels straight after reset.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not idle after reset");

endmodule

bind ring_bloom_led_mapper_unit rblm_chk u_rblm_chk (.*);
